### hw/rtl/glyph_table_text_metrics_assert.svh
// Assertion helpers for the glyph table block
`ifndef GLYPH_TABLE_TEXT_METRICS_ASSERT_SVH
`define GLYPH_TABLE_TEXT_METRICS_ASSERT_SVH

// Clocked check, masked during reset
`define GTM_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("glyph table check failed");

// Clocked check that also runs during reset
`define GTM_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("glyph table check failed");

`endif

### hw/rtl/gtm_pkg.sv
package gtm_pkg;

  localparam int TableDepthDef = 256;
  localparam int CodeW = 17;
  localparam int ValW  = 18;
  localparam int GrpSize = 16;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CHAR  = 2'd2;
  localparam logic [1:0] FUNC_EMPTY = 2'd3;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // insert request broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [CodeW-1:0] code;
    logic [7:0]       w;
    logic [7:0]       h;
  } ins_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [7:0]       w;
    logic [7:0]       h;
    logic             gt;
    logic             eq;
  } link_t;

endpackage

### hw/rtl/gtm_cell.sv
module gtm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                  clk,
  input  logic [CW-1:0]         cnt,
  input  gtm_pkg::ins_t         ins,
  input  logic [gtm_pkg::ValW-1:0] query,
  input  gtm_pkg::link_t        left,
  output gtm_pkg::link_t        right,
  output logic                  hit,
  output logic [7:0]            hit_w,
  output logic [7:0]            hit_h
);
  import gtm_pkg::*;

  logic [CodeW-1:0] code_r, code_nxt;
  logic [7:0]       w_r, w_nxt, h_r, h_nxt;
  logic             valid, at_cnt;

  assign valid  = cnt > CW'(IDX);
  assign at_cnt = cnt == CW'(IDX);

  // compares against the insert code and the lookup value
  assign right.code = code_r;
  assign right.w    = w_r;
  assign right.h    = h_r;
  assign right.gt   = valid && (code_r > ins.code);
  assign right.eq   = valid && ({1'b0, code_r} == query);

  // first of a run of equal codes owns the hit
  assign hit   = right.eq && !left.eq;
  assign hit_w = hit ? w_r : 8'd0;
  assign hit_h = hit ? h_r : 8'd0;

  // sorted insert: shift right from the insert point
  always_comb begin
    code_nxt = code_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    if (ins.en) begin
      if (left.gt) begin
        code_nxt = left.code;
        w_nxt    = left.w;
        h_nxt    = left.h;
      end else if (right.gt || at_cnt) begin
        code_nxt = ins.code;
        w_nxt    = ins.w;
        h_nxt    = ins.h;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
  end

endmodule

### hw/rtl/glyph_table_text_metrics.sv
// Glyph table with text metrics.
// Commands enter on start/in_* when busy is low. func selects clear table,
// add glyph, text character or empty text. The one config bit (font id set)
// is written on cfg_valid/cfg_ready and should change only while idle.
// Clear, add and empty text complete with busy low: the add acknowledgement
// or the empty-text result appears with out_valid in the next cycle.
// A text character holds busy high while it runs: the query value is
// registered, every cell of the glyph chain compares it, hits are merged in
// groups of 16 and then across groups, and the text state is updated.
// The result of the character flagged last comes out with out_valid in the
// cycle after that. out_valid lasts one cycle; the receiver takes it then.
// Glyphs are inserted sorted: each cell either keeps its entry, takes its
// left neighbor's entry or takes the new glyph, all at the same clock edge.
// Reset clears entry count, font maxima, text progress and the config bit;
// table contents are not cleared and are only read below the entry count.
module glyph_table_text_metrics #(
  parameter int TABLE_DEPTH = gtm_pkg::TableDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [16:0] in_code,
  input  logic [7:0]  in_glyph_width,
  input  logic [7:0]  in_glyph_height,
  input  logic        in_last,
  output logic        out_valid,
  output logic        out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_text_width,
  output logic [7:0]  out_text_height,
  output logic [7:0]  out_font_height,
  output logic [7:0]  out_font_width,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import gtm_pkg::*;
  `include "glyph_table_text_metrics_assert.svh"

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int NGRP = (TABLE_DEPTH + GrpSize - 1) / GrpSize;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED1 = 2'd1;
  localparam logic [1:0] S_RED2 = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic            font_id_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [7:0]      maxh_r, maxh_nxt, maxw_r, maxw_nxt;
  logic [7:0]      prefix_r, prefix_nxt;
  logic [16:0]     wsum_r, wsum_nxt;
  logic [7:0]      hsum_r, hsum_nxt;
  logic            fl_space_r, fl_pict_r, fl_np_r, fl_start_r;
  logic            fl_space_nxt, fl_pict_nxt, fl_np_nxt, fl_start_nxt;
  logic [ValW-1:0] v_r, v_nxt;
  logic            last_r, last_nxt;
  logic            accept;

  logic            ov_r, ov_nxt, ok_r, ok_nxt;
  logic [1:0]      ost_r, ost_nxt;
  logic [15:0]     ow_r, ow_nxt;
  logic [7:0]      oh_r, oh_nxt;

  ins_t            ins;
  link_t           links [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] hits;
  logic [7:0]      hw [TABLE_DEPTH];
  logic [7:0]      hh [TABLE_DEPTH];

  logic [NGRP-1:0] g_hit_r;
  logic [7:0]      g_w_r [NGRP];
  logic [7:0]      g_h_r [NGRP];
  logic            found_r;
  logic [7:0]      fw_r, fh_r;

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // insert broadcast
  assign ins.en   = accept && (in_func == FUNC_ADD) && (count_r < CW'(TABLE_DEPTH));
  assign ins.code = in_code;
  assign ins.w    = in_glyph_width;
  assign ins.h    = in_glyph_height;

  assign links[0] = '0;

  // chain of glyph cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    gtm_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk   (clk),
      .cnt   (count_r),
      .ins   (ins),
      .query (v_r),
      .left  (links[i]),
      .right (links[i+1]),
      .hit   (hits[i]),
      .hit_w (hw[i]),
      .hit_h (hh[i])
    );
  end

  // first merge stage: OR within each group of cells
  always_ff @(posedge clk) begin
    logic       hv;
    logic [7:0] wv, hgt;
    for (int g = 0; g < NGRP; g++) begin
      hv  = 1'b0;
      wv  = 8'd0;
      hgt = 8'd0;
      for (int k = g * GrpSize; k < (g + 1) * GrpSize && k < TABLE_DEPTH; k++) begin
        hv  = hv | hits[k];
        wv  = wv | hw[k];
        hgt = hgt | hh[k];
      end
      g_hit_r[g] <= hv;
      g_w_r[g]   <= wv;
      g_h_r[g]   <= hgt;
    end
  end

  // second merge stage: OR across groups
  always_ff @(posedge clk) begin
    logic [7:0] wv, hgt;
    wv  = 8'd0;
    hgt = 8'd0;
    for (int g = 0; g < NGRP; g++) begin
      wv  = wv | g_w_r[g];
      hgt = hgt | g_h_r[g];
    end
    found_r <= |g_hit_r;
    fw_r    <= wv;
    fh_r    <= hgt;
  end

  // command sequencing and text state
  always_comb begin
    logic [16:0] wadd;
    logic        first, is_pref;
    state_nxt    = state_r;
    count_nxt    = count_r;
    maxh_nxt     = maxh_r;
    maxw_nxt     = maxw_r;
    prefix_nxt   = prefix_r;
    wsum_nxt     = wsum_r;
    hsum_nxt     = hsum_r;
    fl_space_nxt = fl_space_r;
    fl_pict_nxt  = fl_pict_r;
    fl_np_nxt    = fl_np_r;
    fl_start_nxt = fl_start_r;
    v_nxt        = v_r;
    last_nxt     = last_r;
    ov_nxt       = 1'b0;
    ok_nxt       = ok_r;
    ost_nxt      = ost_r;
    ow_nxt       = ow_r;
    oh_nxt       = oh_r;
    wadd         = wsum_r + {9'd0, fw_r};
    first        = !fl_start_r;
    is_pref      = v_r inside {[18'd240:18'd255]};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_CLEAR: count_nxt = '0;
            FUNC_ADD: begin
              ov_nxt = 1'b1;
              ok_nxt = KIND_ACK;
              ow_nxt = 16'd0;
              oh_nxt = 8'd0;
              if (ins.en) begin
                ost_nxt   = ST_OK;
                count_nxt = count_r + CW'(1);
                if (maxh_r < in_glyph_height) maxh_nxt = in_glyph_height;
                if (maxw_r < in_glyph_width)  maxw_nxt = in_glyph_width;
              end else begin
                ost_nxt = ST_FULL;
              end
            end
            FUNC_EMPTY: begin
              ov_nxt       = 1'b1;
              ok_nxt       = KIND_TEXT;
              ost_nxt      = ST_OK;
              ow_nxt       = 16'd0;
              oh_nxt       = font_id_r ? maxh_r : 8'd0;
              prefix_nxt   = 8'd0;
              wsum_nxt     = 17'd0;
              hsum_nxt     = 8'd0;
              fl_space_nxt = 1'b0;
              fl_pict_nxt  = 1'b0;
              fl_np_nxt    = 1'b0;
              fl_start_nxt = 1'b0;
            end
            default: begin
              v_nxt      = {1'b0, in_code} + {2'b00, prefix_r, 8'd0};
              last_nxt   = in_last;
              prefix_nxt = 8'd0;
              state_nxt  = S_RED1;
            end
          endcase
        end
      end
      S_RED1: state_nxt = S_RED2;
      S_RED2: state_nxt = S_DONE;
      default: begin
        state_nxt    = S_IDLE;
        fl_start_nxt = 1'b1;
        if (v_r inside {[18'd27:18'd127]}) fl_np_nxt = 1'b1;
        if (v_r > 18'd127) fl_pict_nxt = 1'b1;
        if (is_pref) begin
          prefix_nxt = v_r[7:0];
        end else begin
          if (found_r) wsum_nxt = (wadd > 17'h10000) ? 17'h10000 : wadd;
          if (v_r == 18'd14 && font_id_r) begin
            if (fl_np_nxt || (first && last_r)) hsum_nxt = maxh_r;
          end else if (v_r == 18'd32) begin
            fl_space_nxt = 1'b1;
          end else if (v_r == 18'd12) begin
            hsum_nxt = hsum_r;
          end else if (found_r && hsum_r < fh_r) begin
            hsum_nxt = fh_r;
          end
        end
        if (last_r) begin
          ov_nxt  = 1'b1;
          ok_nxt  = KIND_TEXT;
          ost_nxt = wsum_nxt[16] ? ST_SAT : ST_OK;
          ow_nxt  = wsum_nxt[16] ? 16'hFFFF : wsum_nxt[15:0];
          oh_nxt  = (fl_space_nxt && font_id_r && !fl_pict_nxt) ? maxh_r : hsum_nxt;
          prefix_nxt   = 8'd0;
          wsum_nxt     = 17'd0;
          hsum_nxt     = 8'd0;
          fl_space_nxt = 1'b0;
          fl_pict_nxt  = 1'b0;
          fl_np_nxt    = 1'b0;
          fl_start_nxt = 1'b0;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      font_id_r  <= 1'b0;
      count_r    <= '0;
      maxh_r     <= 8'd0;
      maxw_r     <= 8'd0;
      prefix_r   <= 8'd0;
      wsum_r     <= 17'd0;
      hsum_r     <= 8'd0;
      fl_space_r <= 1'b0;
      fl_pict_r  <= 1'b0;
      fl_np_r    <= 1'b0;
      fl_start_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_valid && cfg_ready) font_id_r <= cfg_data;
      count_r    <= count_nxt;
      maxh_r     <= maxh_nxt;
      maxw_r     <= maxw_nxt;
      prefix_r   <= prefix_nxt;
      wsum_r     <= wsum_nxt;
      hsum_r     <= hsum_nxt;
      fl_space_r <= fl_space_nxt;
      fl_pict_r  <= fl_pict_nxt;
      fl_np_r    <= fl_np_nxt;
      fl_start_r <= fl_start_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    last_r <= last_nxt;
    ok_r   <= ok_nxt;
    ost_r  <= ost_nxt;
    ow_r   <= ow_nxt;
    oh_r   <= oh_nxt;
  end

  assign out_valid       = ov_r;
  assign out_kind        = ok_r;
  assign out_status      = ost_r;
  assign out_text_width  = ow_r;
  assign out_text_height = oh_r;
  assign out_font_height = maxh_r;
  assign out_font_width  = maxw_r;

  `GTM_CHECK(a_red_seq, (state_r == S_RED1) |=> (state_r == S_RED2))
  `GTM_CHECK(a_sat_width, (out_valid && out_status == ST_SAT) |-> (out_text_width == 16'hFFFF))
  `GTM_CHECK(a_count_max, count_r <= CW'(TABLE_DEPTH))
  `GTM_CHECK_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid))

endmodule
